FILE: sv/base32_codec_macros.svh
// assertion macros shared by the base32 codec rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef BASE32_CODEC_MACROS_SVH
`define BASE32_CODEC_MACROS_SVH

// same-cycle implication, checked outside reset
`define B32_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base32 codec check failed");

// next-cycle implication, checked outside reset
`define B32_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base32 codec check failed");

`endif

FILE: sv/b32_pkg.sv
// types, constants and symbol mapping functions for the base32 codec
// no dependencies; imported by every module of the codec
package b32_pkg;

	// job queue between front and back
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// at most three results per input word
	localparam int MAX_RES   = 3;
	localparam int RES_CNT_W = 2;

	// character codes
	localparam logic [7:0] CHAR_UC_A   = 8'h41;
	localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
	localparam logic [7:0] CHAR_LC_A   = 8'h61;
	localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
	localparam logic [7:0] CHAR_TWO    = 8'h32;
	localparam logic [7:0] CHAR_SEVEN  = 8'h37;
	localparam logic [7:0] NUM_LETTERS = 8'd26;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_in;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       stream_end;
		logic       bad_symbol;
	} result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]        n;
		result_t [MAX_RES-1:0]       res;
	} job_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] val;
	} sym_t;

	// 5-bit value to lowercase alphabet character
	function automatic logic [7:0] enc_char(input logic [4:0] idx);
		logic [7:0] code;
		if ({3'b000, idx} < NUM_LETTERS) begin
			code = CHAR_LC_A + {3'b000, idx};
		end else begin
			code = CHAR_TWO + {3'b000, idx} - NUM_LETTERS;
		end
		return code;
	endfunction

	// character to 5-bit value, either letter case accepted
	function automatic sym_t dec_sym(input logic [7:0] s);
		sym_t r;
		logic [7:0] d;
		d = s - CHAR_TWO + NUM_LETTERS;
		priority if ((s >= CHAR_UC_A && s <= CHAR_UC_Z) || (s >= CHAR_LC_A && s <= CHAR_LC_Z)) begin
			r.ok  = 1'b1;
			r.val = s[4:0] - 5'd1;
		end else if (s >= CHAR_TWO && s <= CHAR_SEVEN) begin
			r.ok  = 1'b1;
			r.val = d[4:0];
		end else begin
			r.ok  = 1'b0;
			r.val = 5'd0;
		end
		return r;
	endfunction

endpackage

FILE: sv/b32_front.sv
// front part of the base32 codec: accepts words, holds the bit buffer
// and builds one job of up to three results per word; uses b32_pkg
module b32_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	input  logic            push,
	input  b32_pkg::item_t  item,
	input  b32_pkg::qstat_t qstat,
	output logic            full,
	output logic            job_push,
	output b32_pkg::job_t   job
);
	import b32_pkg::*;

	logic       dir_q;
	logic [6:0] bbuf_q;
	logic [2:0] bcnt_q;
	logic       err_q;

	logic       accept;
	logic [6:0] nbuf;
	logic [2:0] ncnt;
	logic       nerr;

	function automatic logic [11:0] low_mask(input logic [3:0] w);
		return (12'd1 << w) - 12'd1;
	endfunction

	assign full     = qstat.full;
	assign accept   = push && !qstat.full;
	assign job_push = accept && (job.n != '0);

	always_comb begin
		logic [11:0] wbuf;
		logic [3:0]  cnt;
		logic [RES_CNT_W-1:0] n;
		sym_t        sv;
		job          = '0;
		n            = '0;
		nbuf         = bbuf_q;
		ncnt         = bcnt_q;
		nerr         = err_q;
		wbuf         = '0;
		cnt          = '0;
		sv           = dec_sym(item.symbol);
		if (dir_q == DIR_ENCODE) begin
			wbuf = {bbuf_q[3:0], item.symbol};
			cnt  = {1'b0, bcnt_q} + 4'd8 - 4'd5;
			job.res[n].out_byte = enc_char(5'(wbuf >> cnt));
			n = n + 2'd1;
			if (cnt >= 4'd5) begin
				cnt = cnt - 4'd5;
				job.res[n].out_byte = enc_char(5'(wbuf >> cnt));
				n = n + 2'd1;
			end
			if (item.last_in && cnt != 4'd0) begin
				job.res[n].out_byte = enc_char(5'(wbuf << (4'd5 - cnt)));
				n = n + 2'd1;
				cnt = 4'd0;
			end
			nbuf = 7'(wbuf & low_mask(cnt));
			ncnt = 3'(cnt);
			job.res[n - 2'd1].run_end    = 1'b1;
			job.res[n - 2'd1].stream_end = item.last_in;
		end else if (err_q) begin
			// words after an error are dropped until the stream ends
			n = '0;
		end else if (!sv.ok) begin
			job.res[0] = '{out_byte: 8'd0, run_end: 1'b1, stream_end: 1'b1, bad_symbol: 1'b1};
			n    = 2'd1;
			nbuf = '0;
			ncnt = '0;
			nerr = 1'b1;
		end else begin
			wbuf = {bbuf_q, sv.val};
			cnt  = {1'b0, bcnt_q} + 4'd5;
			if (cnt >= 4'd8) begin
				cnt = cnt - 4'd8;
				job.res[n].out_byte = 8'(wbuf >> cnt);
				n = n + 2'd1;
			end
			if (item.last_in) begin
				// trailing zero byte closes a valid stream
				job.res[n].out_byte = 8'd0;
				n = n + 2'd1;
				cnt = 4'd0;
			end
			nbuf = 7'(wbuf & low_mask(cnt));
			ncnt = 3'(cnt);
			if (n != '0) begin
				job.res[n - 2'd1].run_end    = 1'b1;
				job.res[n - 2'd1].stream_end = item.last_in;
			end
		end
		if (item.last_in) begin
			nbuf = '0;
			ncnt = '0;
			nerr = 1'b0;
		end
		job.n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			bbuf_q <= '0;
			bcnt_q <= '0;
			err_q  <= 1'b0;
		end else if (cfg_we) begin
			dir_q  <= cfg_wdata;
			bbuf_q <= '0;
			bcnt_q <= '0;
			err_q  <= 1'b0;
		end else if (accept) begin
			bbuf_q <= nbuf;
			bcnt_q <= ncnt;
			err_q  <= nerr;
		end
	end

endmodule

FILE: sv/b32_queue.sv
// short job queue between the front and back parts of the base32 codec
// register based, depth from b32_pkg
module b32_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  b32_pkg::job_t   wr_job,
	input  logic            rd_en,
	output b32_pkg::job_t   rd_job,
	output b32_pkg::qstat_t stat
);
	import b32_pkg::*;

	job_t                 slot_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_CNT_W-1:0] count_q;

	function automatic logic [JOB_PTR_W-1:0] ptr_inc(input logic [JOB_PTR_W-1:0] p);
		return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_job     = slot_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == JOB_CNT_W'(JOB_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/b32_back.sv
// back part of the base32 codec: walks the head job one result a cycle into
// the output register while that register is free or popped; uses b32_pkg
module b32_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b32_pkg::job_t   head,
	input  b32_pkg::qstat_t qstat,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output b32_pkg::result_t result
);
	import b32_pkg::*;

	logic [RES_CNT_W-1:0] idx_q;
	logic                 out_valid_q;
	result_t              out_q;
	logic                 load;
	logic                 take;

	assign take   = pop && out_valid_q;
	assign load   = qstat.valid && (!out_valid_q || take);
	assign q_pop  = load && (idx_q == head.n - 2'd1);
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.res[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= q_pop ? '0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/base32_codec.sv
// top level of the streaming base32 codec
// depends on b32_pkg, b32_front, b32_queue, b32_back and base32_codec_macros.svh
//
// Streaming base32 codec, lowercase alphabet, no '=' padding. direction 0
// encodes bytes to characters, 1 decodes characters (either case) to bytes;
// a write to direction also restarts the stream. Each input word gives one to
// three result words (encode) or up to two (decode, with a zero byte closing a
// valid stream and a single bad_symbol word on an invalid character). An input
// word is taken whenever the two-entry job queue has room; the back end
// delivers one result word per cycle as long as results are popped, so
// encode throughput is set by the output side. A pushed word is written into
// a job queue slot and then into the output register before its first
// result shows. Results are kept while pop is low, and input is taken
// independently of the result side until the queue fills.
module base32_codec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              push,
	output logic              full,
	input  b32_pkg::item_t    item,
	output logic              empty,
	input  logic              pop,
	output b32_pkg::result_t  result
);
	import b32_pkg::*;
	`include "base32_codec_macros.svh"

	// job handoff between front and back
	job_t   fr_job;
	logic   fr_push;
	job_t   q_head;
	qstat_t q_stat;
	logic   bk_pop;

	// front: classify, track bit buffer, build the job for each word
	b32_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.item     (item),
		.qstat    (q_stat),
		.full     (full),
		.job_push (fr_push),
		.job      (fr_job)
	);

	// queue lets front and back stall independently
	b32_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (fr_push),
		.wr_job(fr_job),
		.rd_en (bk_pop),
		.rd_job(q_head),
		.stat  (q_stat)
	);

	// back: one result word per cycle into the output register while it is free or popped
	b32_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (q_head),
		.qstat (q_stat),
		.q_pop (bk_pop),
		.pop   (pop),
		.empty (empty),
		.result(result)
	);

	// error word carries a zero byte and closes its run and the stream
	`B32_ASSERT_IMP(a_bad_word, !empty && result.bad_symbol, result.out_byte == 8'd0 && result.run_end && result.stream_end)
	// end of stream is always the end of a run
	`B32_ASSERT_IMP(a_stream_run, !empty && result.stream_end, result.run_end)
	// rest of a run follows without a gap once a word is taken
	`B32_ASSERT_NXT(a_run_cont, !empty && pop && !result.run_end, !empty)

endmodule
